[rtl/smie_pkg.sv]
// Shared types and constants for the P-machine instruction executor.
// Holds the input and result item structs, opcodes, status codes and states.
// Depends on nothing.
package smie_pkg;

	localparam int STACK_DEPTH = 2048;
	localparam int CODE_DEPTH  = 512;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int PC_W        = $clog2(CODE_DEPTH);

	typedef struct packed {
		logic [3:0]         op;
		logic [1:0]         lex_level;
		logic signed [15:0] operand_m;
		logic signed [31:0] read_value;
	} in_item_t;

	typedef struct packed {
		logic [8:0]         next_pc;
		logic [10:0]        frame_base;
		logic [10:0]        stack_top_index;
		logic               write_valid;
		logic signed [31:0] write_value;
		logic               halted;
		logic [2:0]         status;
	} out_item_t;

	// opcodes
	localparam logic [3:0] OP_LIT = 4'd1;
	localparam logic [3:0] OP_OPR = 4'd2;
	localparam logic [3:0] OP_LOD = 4'd3;
	localparam logic [3:0] OP_STO = 4'd4;
	localparam logic [3:0] OP_CAL = 4'd5;
	localparam logic [3:0] OP_INC = 4'd6;
	localparam logic [3:0] OP_JMP = 4'd7;
	localparam logic [3:0] OP_JPC = 4'd8;
	localparam logic [3:0] OP_SIO = 4'd9;

	// OPR codes (low four bits once range is checked)
	localparam logic [3:0] OPR_RET = 4'd0;
	localparam logic [3:0] OPR_NEG = 4'd1;
	localparam logic [3:0] OPR_ADD = 4'd2;
	localparam logic [3:0] OPR_SUB = 4'd3;
	localparam logic [3:0] OPR_MUL = 4'd4;
	localparam logic [3:0] OPR_DIV = 4'd5;
	localparam logic [3:0] OPR_ODD = 4'd6;
	localparam logic [3:0] OPR_MOD = 4'd7;
	localparam logic [3:0] OPR_EQL = 4'd8;
	localparam logic [3:0] OPR_NEQ = 4'd9;
	localparam logic [3:0] OPR_LSS = 4'd10;
	localparam logic [3:0] OPR_LEQ = 4'd11;
	localparam logic [3:0] OPR_GTR = 4'd12;
	localparam logic [3:0] OPR_GEQ = 4'd13;
	localparam logic signed [15:0] OPR_LAST = 16'sd13;

	// SIO modes
	localparam logic signed [15:0] SIO_WRITE = 16'sd1;
	localparam logic signed [15:0] SIO_READ  = 16'sd2;
	localparam logic signed [15:0] SIO_HALT  = 16'sd3;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_OP  = 3'd1;
	localparam logic [2:0] ST_DIV0    = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_BAD_SIO = 3'd4;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_WALK, S_WALK_RD, S_LOD, S_STO,
		S_CAL2, S_CAL3, S_CAL4, S_JPC, S_SIOW, S_RET1, S_RET2, S_UNARY,
		S_OPA, S_OPB, S_EXEC, S_DIV, S_DIV_FIN, S_WRES, S_DONE
	} state_t;

endpackage

[rtl/stack_machine_instruction_executor.sv]
// P-machine instruction executor: one instruction per input item, one result item each.
// LIT, INC, JMP, SIO read and halt finish in decode; JPC, SIO write, NEG and ODD read the stack
// top first; RET reads two link words; LOD and STO walk static links through S_WALK and S_WALK_RD;
// CAL walks links, then writes a frame; other OPR read two operands; DIV and MOD use a 32-step divider.
// Throughput: one item at a time, accepted the cycle after the previous result is loaded.
// Reset: clear 2048 stack words, one per cycle, no item accepted; pc 0, bp 1, sp 0.
module stack_machine_instruction_executor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  smie_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output smie_pkg::out_item_t  out_item
);
	import smie_pkg::*;

	logic [31:0] mem [STACK_DEPTH];
	logic        mem_we;
	logic [SP_W-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd, mem_rd_q;

	state_t state_q, state_d;
	logic [PC_W-1:0] pc_q, pc_d;
	logic [SP_W-1:0] bp_q, bp_d, sp_q, sp_d, clr_q, clr_d, idx_q, idx_d;
	logic halt_q, halt_d;
	logic [3:0] op_q;
	logic [1:0] lev_q, lvl_q, lvl_d;
	logic signed [15:0] m_q;
	logic [31:0] rdv_q;
	logic signed [31:0] base_q, base_d, opa_q, opa_d, opb_q, opb_d, res_q, res_d;
	logic [2:0] st_q, st_d;
	logic wv_q, wv_d;
	logic [31:0] wval_q, wval_d;
	logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
	logic [4:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;
	out_item_t out_q, out_d;

	logic accept;
	logic signed [16:0] inc_sum;
	logic signed [32:0] idx_sum;
	logic [11:0] sp_p4;
	logic [32:0] div_sh, div_diff;
	logic [31:0] mag_a, mag_b;
	logic [63:0] prod;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	// stack memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[mem_ra];
	end

	// shared datapath pieces
	assign inc_sum  = $signed({6'b0, sp_q}) + 17'(m_q);
	assign idx_sum  = 33'(base_q) + 33'(m_q);
	assign sp_p4    = {1'b0, sp_q} + 12'd4;
	assign div_sh   = {rem_q, quo_q[31]};
	assign div_diff = div_sh - {1'b0, dvs_q};
	assign mag_a    = opa_q[31] ? 32'(-opa_q) : 32'(opa_q);
	assign mag_b    = opb_q[31] ? 32'(-opb_q) : 32'(opb_q);
	assign prod     = opa_q * opb_q;

	// hold instruction fields on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_item.op;
			lev_q <= in_item.lex_level;
			m_q   <= in_item.operand_m;
			rdv_q <= in_item.read_value;
		end
	end

	// state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pc_q        <= '0;
			bp_q        <= SP_W'(1);
			sp_q        <= '0;
			halt_q      <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pc_q        <= pc_d;
			bp_q        <= bp_d;
			sp_q        <= sp_d;
			halt_q      <= halt_d;
			clr_q       <= clr_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		lvl_q  <= lvl_d;
		base_q <= base_d;
		opa_q  <= opa_d;
		opb_q  <= opb_d;
		res_q  <= res_d;
		st_q   <= st_d;
		wv_q   <= wv_d;
		wval_q <= wval_d;
		rem_q  <= rem_d;
		quo_q  <= quo_d;
		dvs_q  <= dvs_d;
		cnt_q  <= cnt_d;
		out_q  <= out_d;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		pc_d = pc_q; bp_d = bp_q; sp_d = sp_q; halt_d = halt_q; clr_d = clr_q;
		idx_d = idx_q; lvl_d = lvl_q; base_d = base_q;
		opa_d = opa_q; opb_d = opb_q; res_d = res_q;
		st_d = st_q; wv_d = wv_q; wval_d = wval_q;
		rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
		out_d = out_q;
		out_valid_d = out_valid_q && out_stall;
		mem_we = 1'b0; mem_wa = sp_q; mem_wd = '0; mem_ra = sp_q;

		unique case (state_q)
			// zero the stack after reset
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				clr_d  = clr_q + 1'b1;
				if (clr_q == SP_W'(STACK_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (!halt_q) begin
						pc_d = pc_q + 1'b1;
					end
					st_d = ST_OK; wv_d = 1'b0; wval_d = '0;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				if (!halt_q) begin
					priority case (op_q)
						OP_LIT: begin
							if (sp_q == SP_W'(STACK_DEPTH - 1)) begin
								st_d = ST_RANGE;
							end else begin
								mem_we = 1'b1; mem_wa = sp_q + 1'b1; mem_wd = 32'(m_q);
								sp_d = sp_q + 1'b1;
							end
						end
						OP_INC: begin
							if (inc_sum < 0 || inc_sum >= STACK_DEPTH) begin
								st_d = ST_RANGE;
							end else begin
								sp_d = inc_sum[SP_W-1:0];
							end
						end
						OP_JMP: pc_d = m_q[PC_W-1:0];
						OP_JPC: begin
							if (sp_q == '0) begin
								st_d = ST_RANGE;
							end else begin
								state_d = S_JPC;
							end
						end
						OP_SIO: begin
							if (m_q == SIO_WRITE) begin
								if (sp_q == '0) begin
									st_d = ST_RANGE;
								end else begin
									state_d = S_SIOW;
								end
							end else if (m_q == SIO_READ) begin
								if (sp_q == SP_W'(STACK_DEPTH - 1)) begin
									st_d = ST_RANGE;
								end else begin
									mem_we = 1'b1; mem_wa = sp_q + 1'b1; mem_wd = rdv_q;
									sp_d = sp_q + 1'b1;
								end
							end else if (m_q == SIO_HALT) begin
								halt_d = 1'b1;
							end else begin
								st_d = ST_BAD_SIO;
							end
						end
						OP_LOD, OP_STO, OP_CAL: begin
							base_d  = 32'(bp_q);
							lvl_d   = lev_q;
							state_d = S_WALK;
						end
						OP_OPR: begin
							if (m_q < 0 || m_q > OPR_LAST) begin
								st_d = ST_BAD_OP;
							end else if (m_q[3:0] == OPR_RET) begin
								if (bp_q == '0 || bp_q > SP_W'(STACK_DEPTH - 4)) begin
									st_d = ST_RANGE;
								end else begin
									mem_ra = bp_q + SP_W'(2);
									state_d = S_RET1;
								end
							end else if (m_q[3:0] == OPR_NEG || m_q[3:0] == OPR_ODD) begin
								state_d = S_UNARY;
							end else if (sp_q == '0) begin
								st_d = ST_RANGE;
							end else begin
								mem_ra = sp_q - 1'b1;
								state_d = S_OPA;
							end
						end
						default: st_d = ST_BAD_OP;
					endcase
				end
			end
			// walk static links, one level per pass through S_WALK and S_WALK_RD
			S_WALK: begin
				if (lvl_q != '0) begin
					if (base_q < -1 || base_q > STACK_DEPTH - 2) begin
						st_d = ST_RANGE;
						state_d = S_DONE;
					end else begin
						mem_ra  = SP_W'(base_q + 1);
						lvl_d   = lvl_q - 1'b1;
						state_d = S_WALK_RD;
					end
				end else begin
					idx_d = idx_sum[SP_W-1:0];
					state_d = S_DONE;
					priority case (op_q)
						OP_LOD: begin
							if (idx_sum < 0 || idx_sum >= STACK_DEPTH ||
							    sp_q == SP_W'(STACK_DEPTH - 1)) begin
								st_d = ST_RANGE;
							end else begin
								mem_ra = idx_sum[SP_W-1:0];
								state_d = S_LOD;
							end
						end
						OP_STO: begin
							if (idx_sum < 0 || idx_sum >= STACK_DEPTH || sp_q == '0) begin
								st_d = ST_RANGE;
							end else begin
								state_d = S_STO;
							end
						end
						default: begin
							if (sp_p4 > 12'(STACK_DEPTH - 1)) begin
								st_d = ST_RANGE;
							end else begin
								mem_we = 1'b1; mem_wa = sp_q + 1'b1; mem_wd = '0;
								state_d = S_CAL2;
							end
						end
					endcase
				end
			end
			S_WALK_RD: begin
				base_d  = mem_rd_q;
				state_d = S_WALK;
			end
			S_LOD: begin
				mem_we = 1'b1; mem_wa = sp_q + 1'b1; mem_wd = mem_rd_q;
				sp_d = sp_q + 1'b1;
				state_d = S_DONE;
			end
			S_STO: begin
				mem_we = 1'b1; mem_wa = idx_q; mem_wd = mem_rd_q;
				sp_d = sp_q - 1'b1;
				state_d = S_DONE;
			end
			// build the new frame
			S_CAL2: begin
				mem_we = 1'b1; mem_wa = sp_q + SP_W'(2); mem_wd = base_q;
				state_d = S_CAL3;
			end
			S_CAL3: begin
				mem_we = 1'b1; mem_wa = sp_q + SP_W'(3); mem_wd = 32'(bp_q);
				state_d = S_CAL4;
			end
			S_CAL4: begin
				mem_we = 1'b1; mem_wa = sp_q + SP_W'(4); mem_wd = 32'(pc_q);
				bp_d = sp_q + 1'b1;
				pc_d = m_q[PC_W-1:0];
				state_d = S_DONE;
			end
			S_JPC: begin
				if (mem_rd_q == '0) begin
					pc_d = m_q[PC_W-1:0];
				end
				sp_d = sp_q - 1'b1;
				state_d = S_DONE;
			end
			S_SIOW: begin
				wv_d = 1'b1; wval_d = mem_rd_q;
				sp_d = sp_q - 1'b1;
				state_d = S_DONE;
			end
			// return: dynamic link then return address
			S_RET1: begin
				opa_d  = mem_rd_q;
				mem_ra = bp_q + SP_W'(3);
				state_d = S_RET2;
			end
			S_RET2: begin
				if (opa_q < 0 || opa_q >= STACK_DEPTH) begin
					st_d = ST_RANGE;
				end else begin
					pc_d = mem_rd_q[PC_W-1:0];
					sp_d = bp_q - 1'b1;
					bp_d = opa_q[SP_W-1:0];
				end
				state_d = S_DONE;
			end
			S_UNARY: begin
				mem_we = 1'b1;
				mem_wa = sp_q;
				mem_wd = (m_q[3:0] == OPR_NEG) ? 32'(-mem_rd_q) : {31'b0, mem_rd_q[0]};
				state_d = S_DONE;
			end
			S_OPA: begin
				opa_d = mem_rd_q;
				state_d = S_OPB;
			end
			S_OPB: begin
				opb_d = mem_rd_q;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_WRES;
				priority case (m_q[3:0])
					OPR_ADD: res_d = opa_q + opb_q;
					OPR_SUB: res_d = opa_q - opb_q;
					OPR_MUL: res_d = prod[31:0];
					OPR_EQL: res_d = 32'(opa_q == opb_q);
					OPR_NEQ: res_d = 32'(opa_q != opb_q);
					OPR_LSS: res_d = 32'(opa_q <  opb_q);
					OPR_LEQ: res_d = 32'(opa_q <= opb_q);
					OPR_GTR: res_d = 32'(opa_q >  opb_q);
					OPR_GEQ: res_d = 32'(opa_q >= opb_q);
					default: begin
						if (opb_q == '0) begin
							res_d = '0;
							st_d  = ST_DIV0;
						end else begin
							rem_d = '0; quo_d = mag_a; dvs_d = mag_b;
							cnt_d = 5'd31;
							state_d = S_DIV;
						end
					end
				endcase
			end
			// restoring divide, one quotient bit a cycle
			S_DIV: begin
				if (!div_diff[32]) begin
					rem_d = div_diff[31:0];
					quo_d = {quo_q[30:0], 1'b1};
				end else begin
					rem_d = div_sh[31:0];
					quo_d = {quo_q[30:0], 1'b0};
				end
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = S_DIV_FIN;
				end
			end
			S_DIV_FIN: begin
				if (m_q[3:0] == OPR_DIV) begin
					res_d = (opa_q[31] ^ opb_q[31]) ? 32'(-quo_q) : quo_q;
				end else begin
					res_d = opa_q[31] ? 32'(-rem_q) : rem_q;
				end
				state_d = S_WRES;
			end
			S_WRES: begin
				mem_we = 1'b1; mem_wa = sp_q - 1'b1; mem_wd = res_q;
				sp_d = sp_q - 1'b1;
				state_d = S_DONE;
			end
			// load the result item once the output register is free
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_d.next_pc         = pc_q;
					out_d.frame_base      = bp_q;
					out_d.stack_top_index = sp_q;
					out_d.write_valid     = wv_q;
					out_d.write_value     = wval_q;
					out_d.halted          = halt_q;
					out_d.status          = st_q;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[sim/stack_machine_instruction_executor_test.sv]
// Testbench for the P-machine instruction executor: drives instruction items,
// predicts each result with a behavioral copy of the machine, and checks them in order.
// Depends on smie_pkg and the stack_machine_instruction_executor RTL.
`timescale 1ns / 1ps

import smie_pkg::*;

// Keeps the machine copy and the queue of predicted results.
class pmachine_scoreboard;
	logic [31:0] mem [STACK_DEPTH];
	int          sp, bp, pc;
	bit          halt;
	out_item_t   pending [$];
	int          mismatches;

	function new();
		foreach (mem[i]) mem[i] = 0;
		sp = 0;
		bp = 1;
		pc = 0;
		halt = 0;
		mismatches = 0;
	endfunction

	function bit in_range(longint i);
		return i >= 0 && i < STACK_DEPTH;
	endfunction

	function longint sx(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function int code_target(longint v);
		logic [31:0] w;
		w = v[31:0];
		return int'(w % CODE_DEPTH);
	endfunction

	// Walk static links; return 0 when a link index falls outside the stack.
	function bit walk_links(int levels, output longint base);
		longint b;
		b = bp;
		repeat (levels) begin
			if (!in_range(b + 1)) return 0;
			b = sx(mem[b + 1]);
		end
		base = b;
		return 1;
	endfunction

	function logic [2:0] arith(longint code);
		longint a, b, r;
		logic [2:0] st;
		st = ST_OK;
		r = 0;
		if (code < 0 || code > 13) return ST_BAD_OP;
		if (code == OPR_RET) begin
			longint nb;
			if (bp < 1 || !in_range(bp + 3)) return ST_RANGE;
			nb = sx(mem[bp + 2]);
			if (!in_range(nb)) return ST_RANGE;
			pc = code_target(sx(mem[bp + 3]));
			sp = bp - 1;
			bp = int'(nb);
			return ST_OK;
		end
		if (code == OPR_NEG) begin
			mem[sp] = 32'd0 - mem[sp];
			return ST_OK;
		end
		if (code == OPR_ODD) begin
			mem[sp] = mem[sp] & 32'd1;
			return ST_OK;
		end
		if (sp < 1) return ST_RANGE;
		a = sx(mem[sp - 1]);
		b = sx(mem[sp]);
		case (code[3:0])
			OPR_ADD: r = a + b;
			OPR_SUB: r = a - b;
			OPR_MUL: r = a * b;
			OPR_DIV: if (b == 0) st = ST_DIV0; else r = a / b;
			OPR_MOD: if (b == 0) st = ST_DIV0; else r = a % b;
			OPR_EQL: r = (a == b);
			OPR_NEQ: r = (a != b);
			OPR_LSS: r = (a < b);
			OPR_LEQ: r = (a <= b);
			OPR_GTR: r = (a > b);
			default: r = (a >= b);
		endcase
		mem[sp - 1] = r[31:0];
		sp = sp - 1;
		return st;
	endfunction

	// Execute one accepted instruction and queue the result it should give.
	function void note_instruction(in_item_t it);
		out_item_t  res;
		logic [2:0] st;
		longint     m, base, idx;
		int         lev;
		st = ST_OK;
		res = '0;
		m = it.operand_m;
		lev = it.lex_level;
		base = 0;
		if (!halt) begin
			pc = (pc + 1) % CODE_DEPTH;
			case (it.op)
				OP_LIT: if (!in_range(sp + 1)) st = ST_RANGE;
					else begin
						mem[sp + 1] = m[31:0];
						sp++;
					end
				OP_OPR: st = arith(m);
				OP_LOD: begin
					if (!walk_links(lev, base)) st = ST_RANGE;
					else begin
						idx = base + m;
						if (!in_range(idx) || !in_range(sp + 1)) st = ST_RANGE;
						else begin
							mem[sp + 1] = mem[idx];
							sp++;
						end
					end
				end
				OP_STO: begin
					if (!walk_links(lev, base)) st = ST_RANGE;
					else begin
						idx = base + m;
						if (!in_range(idx) || sp < 1) st = ST_RANGE;
						else begin
							mem[idx] = mem[sp];
							sp--;
						end
					end
				end
				OP_CAL: begin
					if (!walk_links(lev, base) || !in_range(sp + 4)) st = ST_RANGE;
					else begin
						mem[sp + 1] = 0;
						mem[sp + 2] = base[31:0];
						mem[sp + 3] = bp;
						mem[sp + 4] = pc;
						bp = sp + 1;
						pc = code_target(m);
					end
				end
				OP_INC: if (!in_range(sp + m)) st = ST_RANGE;
					else sp = int'(sp + m);
				OP_JMP: pc = code_target(m);
				OP_JPC: if (sp < 1) st = ST_RANGE;
					else begin
						if (mem[sp] == 0) pc = code_target(m);
						sp--;
					end
				OP_SIO: begin
					if (m == SIO_WRITE) begin
						if (sp < 1) st = ST_RANGE;
						else begin
							res.write_valid = 1;
							res.write_value = mem[sp];
							sp--;
						end
					end else if (m == SIO_READ) begin
						if (!in_range(sp + 1)) st = ST_RANGE;
						else begin
							mem[sp + 1] = it.read_value;
							sp++;
						end
					end else if (m == SIO_HALT) halt = 1;
					else st = ST_BAD_SIO;
				end
				default: st = ST_BAD_OP;
			endcase
		end
		res.next_pc = pc[8:0];
		res.frame_base = bp[10:0];
		res.stack_top_index = sp[10:0];
		res.halted = halt;
		res.status = st;
		pending.push_back(res);
	endfunction

	// Compare one result with the oldest prediction.
	function void check_result(out_item_t got);
		out_item_t exp_res;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %p", got);
			return;
		end
		exp_res = pending.pop_front();
		if (got.next_pc !== exp_res.next_pc || got.frame_base !== exp_res.frame_base
		    || got.stack_top_index !== exp_res.stack_top_index
		    || got.write_valid !== exp_res.write_valid
		    || got.write_value !== exp_res.write_value
		    || got.halted !== exp_res.halted || got.status !== exp_res.status) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected %p, got %p", exp_res, got);
		end
	endfunction
endclass

module stack_machine_instruction_executor_test;
	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	pmachine_scoreboard board;
	bit  calm;       // no idling on either side while set
	int  quiet_cycles;
	int  sent_count;

	stack_machine_instruction_executor i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Check results and stall the receiver at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) board.check_result(out_item);
			out_stall <= !calm && ($urandom_range(99) < 24);
		end
	end

	// Count cycles with no handshake; give up past the limit.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Present one instruction, hold it until taken, then note it.
	// Valid stays high after the accept; the next call or a drain replaces or drops it.
	task send_instr(logic [3:0] op, logic [1:0] lev, logic [15:0] m, logic [31:0] rd);
		if (!calm && $urandom_range(99) < 24) begin
			in_valid <= 0;
			@(posedge clk);
			while (!calm && $urandom_range(99) < 24) @(posedge clk);
		end
		in_valid <= 1;
		in_item <= '{op: op, lex_level: lev, operand_m: m, read_value: rd};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_instruction(in_item);
		sent_count++;
	endtask

	// Drop valid and wait until every predicted result has come.
	task drain();
		in_valid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// Random instruction, biased toward stack-friendly forms.
	task send_random();
		int sel;
		logic [15:0] m;
		sel = $urandom_range(99);
		m = $urandom_range(30);
		if (sel < 20) send_instr(OP_LIT, $urandom, $urandom, 0);
		else if (sel < 42) send_instr(OP_OPR, 0, $urandom_range(13), 0);
		else if (sel < 52) send_instr(OP_LOD, $urandom, m, 0);
		else if (sel < 60) send_instr(OP_STO, $urandom, m, 0);
		else if (sel < 64) send_instr(OP_CAL, $urandom, $urandom, 0);
		else if (sel < 70) send_instr(OP_INC, 0, $urandom_range(8), 0);
		else if (sel < 73) send_instr(OP_JMP, 0, $urandom, 0);
		else if (sel < 78) send_instr(OP_JPC, 0, $urandom, 0);
		else if (sel < 84) send_instr(OP_SIO, 0, SIO_WRITE, 0);
		else if (sel < 92) send_instr(OP_SIO, 0, SIO_READ, $urandom);
		else if (sel < 94) send_instr(OP_INC, 0, -$urandom_range(6), 0);
		else send_instr($urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		board = new();
		calm = 0;
		sent_count = 0;
		in_valid = 0;
		in_item = '0;
		out_stall = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Directed: range errors on empty stack, each opcode, extremes.
		send_instr(OP_OPR, 0, OPR_ADD, 0);
		send_instr(OP_SIO, 0, SIO_WRITE, 0);
		send_instr(OP_LIT, 0, 16'sh7fff, 0);
		send_instr(OP_LIT, 3, 16'sh8000, 0);
		send_instr(OP_OPR, 0, OPR_MUL, 0);
		send_instr(OP_LIT, 0, 0, 0);
		send_instr(OP_OPR, 0, OPR_DIV, 0);
		send_instr(OP_SIO, 0, SIO_READ, 32'h8000_0000);
		send_instr(OP_SIO, 0, SIO_READ, 32'hffff_ffff);
		send_instr(OP_OPR, 0, OPR_MOD, 0);
		send_instr(OP_OPR, 0, OPR_NEG, 0);
		send_instr(OP_OPR, 0, OPR_ODD, 0);
		send_instr(OP_OPR, 0, 16'sd14, 0);
		send_instr(OP_OPR, 0, 16'hffff, 0);
		send_instr(4'd0, 0, 0, 0);
		send_instr(4'd15, 3, 0, 0);
		send_instr(OP_SIO, 0, 16'sd7, 0);
		send_instr(OP_INC, 0, 16'sd4, 0);
		send_instr(OP_CAL, 1, 16'sd40, 0);
		send_instr(OP_LOD, 1, 16'sh8000, 0);
		send_instr(OP_STO, 0, 16'sd2, 0);
		send_instr(OP_JPC, 0, 16'sd9, 0);
		send_instr(OP_OPR, 0, OPR_RET, 0);
		send_instr(OP_JMP, 0, 16'hffff, 0);
		send_instr(OP_INC, 0, 16'sh7fff, 0);

		// Random; a calm stretch and a full drain partway through.
		for (int n = 0; n < 500; n++) begin
			if (n == 150) calm = 1;
			if (n == 250) begin
				calm = 0;
				drain();
			end
			send_random();
		end
		send_instr(OP_SIO, 0, SIO_HALT, 0);
		send_instr(OP_LIT, 0, 16'sd5, 0);
		drain();
		repeat (60) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
